>>> rtl/imucf_pkg.sv
`timescale 1ns / 1ps

package imucf_pkg;

   // Fixed widths of the arithmetic.
   localparam int IDX_W       = 5;   // iteration index, covers up to 24 steps
   localparam int SQRT_STEPS  = 24;  // root digits of a 48-bit radicand
   localparam int CORDIC_W    = 28;  // CORDIC x and y, signed
   localparam int ZW          = 34;  // CORDIC angle, degrees with 24 fraction bits
   localparam int TAB_FRAC    = 24;
   localparam int WEIGHT_ONE  = 65536;

   // Fraction bits of the angle results; the 25-bit result ports are sized for it.
   localparam int ANGLE_FRACTION_BITS = 16;

   // Configuration register indexes.
   localparam logic [7:0] REG_BLEND_WEIGHT   = 8'd0;
   localparam logic [7:0] REG_GYRO_STEP_GAIN = 8'd1;

   localparam logic [16:0] BLEND_WEIGHT_RESET   = 17'd64225;
   localparam logic [23:0] GYRO_STEP_GAIN_RESET = 24'd163930;

   // Datapath operations issued by the controller.
   typedef enum logic [3:0] {
      OP_NONE,
      OP_LOAD,
      OP_SQ_A,
      OP_SQ_B,
      OP_SQRT,
      OP_CINIT_P,
      OP_CINIT_R,
      OP_CSTEP,
      OP_CEND_P,
      OP_CEND_R,
      OP_DELTA,
      OP_BLEND_A,
      OP_BLEND_B,
      OP_BLEND_C,
      OP_YAW,
      OP_PUBLISH
   } op_type;

   typedef struct packed {
      op_type           op;
      logic [IDX_W-1:0] idx;
   } cmd_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SQ_A,
      ST_SQ_B,
      ST_SQRT,
      ST_P_INIT,
      ST_P_ITER,
      ST_P_END,
      ST_R_INIT,
      ST_R_ITER,
      ST_R_END,
      ST_DELTA,
      ST_BLEND_A,
      ST_BLEND_B,
      ST_BLEND_C,
      ST_YAW,
      ST_PUBLISH
   } state_type;

   // atan(2^-i) in degrees with 24 fraction bits.
   function automatic logic signed [ZW-1:0] atan_entry(input logic [IDX_W-1:0] i);
      logic signed [ZW-1:0] v;
      case (i)
         5'd0:  v = 34'sd754974720;
         5'd1:  v = 34'sd445687602;
         5'd2:  v = 34'sd235489088;
         5'd3:  v = 34'sd119537938;
         5'd4:  v = 34'sd60000934;
         5'd5:  v = 34'sd30029717;
         5'd6:  v = 34'sd15018523;
         5'd7:  v = 34'sd7509720;
         5'd8:  v = 34'sd3754917;
         5'd9:  v = 34'sd1877466;
         5'd10: v = 34'sd938734;
         5'd11: v = 34'sd469367;
         5'd12: v = 34'sd234683;
         5'd13: v = 34'sd117342;
         5'd14: v = 34'sd58671;
         5'd15: v = 34'sd29335;
         5'd16: v = 34'sd14668;
         5'd17: v = 34'sd7334;
         5'd18: v = 34'sd3667;
         5'd19: v = 34'sd1833;
         5'd20: v = 34'sd917;
         5'd21: v = 34'sd458;
         5'd22: v = 34'sd229;
         5'd23: v = 34'sd115;
         default: v = '0;
      endcase
      return v;
   endfunction

endpackage

>>> rtl/imucf_ctrl.sv
`timescale 1ns / 1ps

module imucf_ctrl #(
   parameter int CORDIC_ITERATIONS = 16
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic              req_read_failed,
   output logic              req_ready,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output imucf_pkg::cmd_type cmd
);

   imucf_pkg::state_type state_ff, state_in;
   logic [imucf_pkg::IDX_W-1:0] cnt_ff, cnt_in;
   logic rsp_valid_ff, rsp_valid_in;

   localparam logic [imucf_pkg::IDX_W-1:0] CORDIC_LAST =
      imucf_pkg::IDX_W'(CORDIC_ITERATIONS - 1);
   localparam logic [imucf_pkg::IDX_W-1:0] SQRT_LAST =
      imucf_pkg::IDX_W'(imucf_pkg::SQRT_STEPS - 1);

   // State, step counter and result valid registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= imucf_pkg::ST_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Sequencing of the datapath operations.
   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      cmd.op       = imucf_pkg::OP_NONE;
      cmd.idx      = cnt_ff;
      req_ready    = 1'b0;
      unique case (state_ff)
         imucf_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid && !req_read_failed) begin
               cmd.op   = imucf_pkg::OP_LOAD;
               state_in = imucf_pkg::ST_SQ_A;
            end
         end
         imucf_pkg::ST_SQ_A: begin
            cmd.op   = imucf_pkg::OP_SQ_A;
            state_in = imucf_pkg::ST_SQ_B;
         end
         imucf_pkg::ST_SQ_B: begin
            cmd.op   = imucf_pkg::OP_SQ_B;
            cnt_in   = '0;
            state_in = imucf_pkg::ST_SQRT;
         end
         imucf_pkg::ST_SQRT: begin
            cmd.op = imucf_pkg::OP_SQRT;
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == SQRT_LAST) begin
               state_in = imucf_pkg::ST_P_INIT;
            end
         end
         imucf_pkg::ST_P_INIT: begin
            cmd.op   = imucf_pkg::OP_CINIT_P;
            cnt_in   = '0;
            state_in = imucf_pkg::ST_P_ITER;
         end
         imucf_pkg::ST_P_ITER: begin
            cmd.op = imucf_pkg::OP_CSTEP;
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == CORDIC_LAST) begin
               state_in = imucf_pkg::ST_P_END;
            end
         end
         imucf_pkg::ST_P_END: begin
            cmd.op   = imucf_pkg::OP_CEND_P;
            state_in = imucf_pkg::ST_R_INIT;
         end
         imucf_pkg::ST_R_INIT: begin
            cmd.op   = imucf_pkg::OP_CINIT_R;
            cnt_in   = '0;
            state_in = imucf_pkg::ST_R_ITER;
         end
         imucf_pkg::ST_R_ITER: begin
            cmd.op = imucf_pkg::OP_CSTEP;
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == CORDIC_LAST) begin
               state_in = imucf_pkg::ST_R_END;
            end
         end
         imucf_pkg::ST_R_END: begin
            cmd.op   = imucf_pkg::OP_CEND_R;
            cnt_in   = '0;
            state_in = imucf_pkg::ST_DELTA;
         end
         imucf_pkg::ST_DELTA: begin
            cmd.op = imucf_pkg::OP_DELTA;
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == imucf_pkg::IDX_W'(2)) begin
               cnt_in   = '0;
               state_in = imucf_pkg::ST_BLEND_A;
            end
         end
         imucf_pkg::ST_BLEND_A: begin
            cmd.op   = imucf_pkg::OP_BLEND_A;
            state_in = imucf_pkg::ST_BLEND_B;
         end
         imucf_pkg::ST_BLEND_B: begin
            cmd.op   = imucf_pkg::OP_BLEND_B;
            state_in = imucf_pkg::ST_BLEND_C;
         end
         imucf_pkg::ST_BLEND_C: begin
            cmd.op   = imucf_pkg::OP_BLEND_C;
            cnt_in   = cnt_ff + 1'b1;
            state_in = imucf_pkg::ST_BLEND_A;
            if (cnt_ff == imucf_pkg::IDX_W'(1)) begin
               state_in = imucf_pkg::ST_YAW;
            end
         end
         imucf_pkg::ST_YAW: begin
            cmd.op   = imucf_pkg::OP_YAW;
            state_in = imucf_pkg::ST_PUBLISH;
         end
         imucf_pkg::ST_PUBLISH: begin
            // Wait until the output register is free.
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.op       = imucf_pkg::OP_PUBLISH;
               rsp_valid_in = 1'b1;
               state_in     = imucf_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = imucf_pkg::ST_IDLE;
         end
      endcase
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

>>> rtl/imucf_datapath.sv
`timescale 1ns / 1ps

module imucf_datapath (
   input  logic                clock,
   input  logic                reset,
   input  imucf_pkg::cmd_type  cmd,
   input  logic                csr_valid,
   input  logic [7:0]          csr_index,
   input  logic [23:0]         csr_wdata,
   input  logic signed [15:0]  req_accel_x,
   input  logic signed [15:0]  req_accel_y,
   input  logic signed [15:0]  req_accel_z,
   input  logic signed [15:0]  req_gyro_x,
   input  logic signed [15:0]  req_gyro_y,
   input  logic signed [15:0]  req_gyro_z,
   output logic signed [24:0]  rsp_pitch_angle,
   output logic signed [24:0]  rsp_roll_angle,
   output logic signed [24:0]  rsp_yaw_angle,
   output logic [31:0]         rsp_sample_count
);

   localparam int F  = imucf_pkg::ANGLE_FRACTION_BITS;
   localparam int AW = F + 10;        // angle registers, signed
   localparam int CW = imucf_pkg::CORDIC_W;
   localparam int ZW = imucf_pkg::ZW;
   localparam int PW = AW + 19;       // blend products
   localparam int SW = PW + 1;        // blend sum
   localparam int YW = AW + 2;        // yaw wrap arithmetic

   localparam logic signed [SW-1:0] LIM     = SW'(256 * (1 << F));
   localparam logic signed [YW-1:0] HALF    = YW'(180 * (1 << F));
   localparam logic signed [YW-1:0] PER     = YW'(360 * (1 << F));
   localparam logic signed [ZW-1:0] Z_HALF  = ZW'(1) << (imucf_pkg::TAB_FRAC - 1 - F);
   localparam logic signed [ZW-1:0] Z_RIGHT = ZW'(90) << imucf_pkg::TAB_FRAC;
   localparam logic signed [40:0]   D_HALF  = 41'(1) << (31 - F);

   // Configuration registers.
   logic [16:0] weight_ff;
   logic [23:0] gain_ff;

   // Captured sample.
   logic signed [15:0] ax_ff, ay_ff, az_ff, gx_ff, gy_ff, gz_ff;

   // Magnitude square root.
   logic [31:0] sq_ff, sq_in;
   logic [47:0] rad_ff, rad_in;
   logic [25:0] rem_ff, rem_in;
   logic [23:0] root_ff, root_in;

   // CORDIC.
   logic signed [CW-1:0] x_ff, x_in, y_ff, y_in;
   logic signed [ZW-1:0] z_ff, z_in;
   logic zero_ff, zero_in;
   logic signed [AW-1:0] pacc_ff, pacc_in, racc_ff, racc_in;

   // Angle steps and blend.
   logic signed [AW-1:0] d_ff [3];
   logic signed [AW-1:0] d_in;
   logic signed [PW-1:0] p1_ff, p1_in, p2_ff, p2_in;

   // Estimates and counter.
   logic signed [AW-1:0] pitch_ff, roll_ff, yaw_ff, est_in, yaw_in;
   logic [31:0] count_ff;

   // Result registers.
   logic signed [24:0] out_pitch_ff, out_roll_ff, out_yaw_ff;
   logic [31:0] out_count_ff;

   // Combinational helpers.
   logic [27:0] sq_rem2;
   logic [27:0] sq_trial;
   logic signed [CW-1:0] xi, yi, sx, sy;
   logic signed [ZW-1:0] zr;
   logic signed [15:0] g_sel;
   logic signed [40:0] dprod, dround;
   logic signed [AW:0] od;
   logic signed [AW-1:0] old_sel, acc_sel;
   logic [16:0] w_eff, w_comp;
   logic signed [SW-1:0] bsum, bround;
   logic signed [YW-1:0] ys;
   logic [31:0] az_sq;

   // Configuration writes; unknown indexes are ignored.
   always_ff @(posedge clock) begin
      if (reset) begin
         weight_ff <= imucf_pkg::BLEND_WEIGHT_RESET;
         gain_ff   <= imucf_pkg::GYRO_STEP_GAIN_RESET;
      end else if (csr_valid) begin
         if (csr_index == imucf_pkg::REG_BLEND_WEIGHT) begin
            weight_ff <= csr_wdata[16:0];
         end else if (csr_index == imucf_pkg::REG_GYRO_STEP_GAIN) begin
            gain_ff <= csr_wdata;
         end
      end
   end

   // Weight above one is used as one.
   assign w_eff  = (weight_ff[16] && (weight_ff[15:0] != 16'd0)) ?
                   17'(imucf_pkg::WEIGHT_ONE) : weight_ff;
   assign w_comp = 17'(imucf_pkg::WEIGHT_ONE) - w_eff;

   // Square root digit step and squares.
   always_comb begin
      az_sq    = 32'($signed(az_ff) * $signed(az_ff));
      sq_rem2  = {rem_ff, rad_ff[47:46]};
      sq_trial = {2'b00, root_ff, 2'b01};
      sq_in    = 32'($signed(ay_ff) * $signed(ay_ff));
      rad_in   = rad_ff;
      rem_in   = rem_ff;
      root_in  = root_ff;
      if (cmd.op == imucf_pkg::OP_SQ_B) begin
         rad_in  = {sq_ff + az_sq, 16'd0};
         rem_in  = '0;
         root_in = '0;
      end else if (cmd.op == imucf_pkg::OP_SQRT) begin
         rad_in = {rad_ff[45:0], 2'b00};
         if (sq_rem2 >= sq_trial) begin
            rem_in  = 26'(sq_rem2 - sq_trial);
            root_in = {root_ff[22:0], 1'b1};
         end else begin
            rem_in  = sq_rem2[25:0];
            root_in = {root_ff[22:0], 1'b0};
         end
      end
   end

   // CORDIC set up, one vectoring step, and final rounding.
   always_comb begin
      if (cmd.op == imucf_pkg::OP_CINIT_P) begin
         xi = $signed({4'b0000, root_ff});
         yi = (-CW'(ax_ff)) <<< 8;
      end else begin
         xi = CW'(az_ff) <<< 8;
         yi = CW'(ay_ff) <<< 8;
      end
      sx      = x_ff >>> cmd.idx;
      sy      = y_ff >>> cmd.idx;
      zr      = (z_ff + Z_HALF) >>> (imucf_pkg::TAB_FRAC - F);
      x_in    = x_ff;
      y_in    = y_ff;
      z_in    = z_ff;
      zero_in = zero_ff;
      pacc_in = pacc_ff;
      racc_in = racc_ff;
      unique case (cmd.op)
         imucf_pkg::OP_CINIT_P, imucf_pkg::OP_CINIT_R: begin
            zero_in = (xi == '0) && (yi == '0);
            if (xi < 0) begin
               // Turn a left half plane vector by a right angle first.
               if (yi >= 0) begin
                  x_in = yi;
                  y_in = -xi;
                  z_in = Z_RIGHT;
               end else begin
                  x_in = -yi;
                  y_in = xi;
                  z_in = -Z_RIGHT;
               end
            end else begin
               x_in = xi;
               y_in = yi;
               z_in = '0;
            end
         end
         imucf_pkg::OP_CSTEP: begin
            if (y_ff >= 0) begin
               x_in = x_ff + sy;
               y_in = y_ff - sx;
               z_in = z_ff + imucf_pkg::atan_entry(cmd.idx);
            end else begin
               x_in = x_ff - sy;
               y_in = y_ff + sx;
               z_in = z_ff - imucf_pkg::atan_entry(cmd.idx);
            end
         end
         imucf_pkg::OP_CEND_P: begin
            pacc_in = zero_ff ? '0 : AW'(zr);
         end
         imucf_pkg::OP_CEND_R: begin
            racc_in = zero_ff ? '0 : AW'(zr);
         end
         default: begin
         end
      endcase
   end

   // Gyro angle step, blend and yaw wrap.
   always_comb begin
      case (cmd.idx[1:0])
         2'd0:    g_sel = gx_ff;
         2'd1:    g_sel = gy_ff;
         default: g_sel = gz_ff;
      endcase
      dprod   = $signed(g_sel) * $signed({1'b0, gain_ff});
      dround  = (dprod + D_HALF) >>> (32 - F);
      d_in    = AW'(dround);
      old_sel = cmd.idx[0] ? roll_ff : pitch_ff;
      acc_sel = cmd.idx[0] ? racc_ff : pacc_ff;
      od      = (AW+1)'(old_sel) + (AW+1)'(d_ff[cmd.idx[0]]);
      p1_in   = $signed({1'b0, w_eff}) * od;
      p2_in   = PW'($signed({1'b0, w_comp}) * acc_sel);
      bsum    = SW'(p1_ff) + SW'(p2_ff);
      bround  = (bsum + SW'(32768)) >>> 16;
      if (bround < -LIM) begin
         est_in = AW'(-LIM);
      end else if (bround > LIM - 1) begin
         est_in = AW'(LIM - 1);
      end else begin
         est_in = AW'(bround);
      end
      ys = YW'(yaw_ff) + YW'(d_ff[2]) + HALF;
      if (ys < 0) begin
         ys = ys + PER;
      end else if (ys >= PER) begin
         ys = ys - PER;
      end
      yaw_in = AW'(ys - HALF);
   end

   // Datapath registers without reset.
   always_ff @(posedge clock) begin
      if (cmd.op == imucf_pkg::OP_LOAD) begin
         ax_ff <= req_accel_x;
         ay_ff <= req_accel_y;
         az_ff <= req_accel_z;
         gx_ff <= req_gyro_x;
         gy_ff <= req_gyro_y;
         gz_ff <= req_gyro_z;
      end
      if (cmd.op == imucf_pkg::OP_SQ_A) begin
         sq_ff <= sq_in;
      end
      rad_ff  <= rad_in;
      rem_ff  <= rem_in;
      root_ff <= root_in;
      x_ff    <= x_in;
      y_ff    <= y_in;
      z_ff    <= z_in;
      zero_ff <= zero_in;
      pacc_ff <= pacc_in;
      racc_ff <= racc_in;
      if (cmd.op == imucf_pkg::OP_DELTA) begin
         d_ff[cmd.idx[1:0]] <= d_in;
      end
      if (cmd.op == imucf_pkg::OP_BLEND_A) begin
         p1_ff <= p1_in;
      end
      if (cmd.op == imucf_pkg::OP_BLEND_B) begin
         p2_ff <= p2_in;
      end
      if (cmd.op == imucf_pkg::OP_PUBLISH) begin
         out_pitch_ff <= 25'(pitch_ff);
         out_roll_ff  <= 25'(roll_ff);
         out_yaw_ff   <= 25'(yaw_ff);
         out_count_ff <= count_ff;
      end
   end

   // Filter state.
   always_ff @(posedge clock) begin
      if (reset) begin
         pitch_ff <= '0;
         roll_ff  <= '0;
         yaw_ff   <= '0;
         count_ff <= '0;
      end else begin
         if (cmd.op == imucf_pkg::OP_BLEND_C) begin
            if (cmd.idx[0]) begin
               roll_ff <= est_in;
            end else begin
               pitch_ff <= est_in;
            end
         end
         if (cmd.op == imucf_pkg::OP_YAW) begin
            yaw_ff   <= yaw_in;
            count_ff <= count_ff + 32'd1;
         end
      end
   end

   assign rsp_pitch_angle  = out_pitch_ff;
   assign rsp_roll_angle   = out_roll_ff;
   assign rsp_yaw_angle    = out_yaw_ff;
   assign rsp_sample_count = out_count_ff;

endmodule

>>> rtl/imu_complementary_filter.sv
`timescale 1ns / 1ps

// Complementary attitude filter for one six-axis inertial sample per beat.
// Input channel (req_): accelerometer and gyro readings plus a read-failed
// flag. A beat with req_read_failed set is taken and dropped with no result.
// Result channel (rsp_): pitch, roll and yaw in signed fixed-point degrees
// and the count of good samples, one result per good sample, in order.
// Configuration channel (csr_): index 0 writes the blend weight, index 1
// the gyro step gain; csr_ready is always high. Write only while idle.
// A good sample runs from accept to rsp_valid through the 24 square root
// digit steps, the two CORDIC passes on one shared iterative unit, the
// gyro steps, the blends and the yaw update. One sample is in work at a
// time; req_ready is high again right after the result is placed in the
// output register, so the next sample is taken while it waits, but a new
// good sample is not accepted before the previous one has been published.
// If the receiver stalls with a result still held, the next result waits
// in its last step until the output register is free.
// Reset clears the estimates, the counter and all handshakes and restores
// the register defaults.
module imu_complementary_filter #(
   parameter int CORDIC_ITERATIONS = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic signed [15:0] req_accel_x,
   input  logic signed [15:0] req_accel_y,
   input  logic signed [15:0] req_accel_z,
   input  logic signed [15:0] req_gyro_x,
   input  logic signed [15:0] req_gyro_y,
   input  logic signed [15:0] req_gyro_z,
   input  logic               req_read_failed,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic signed [24:0] rsp_pitch_angle,
   output logic signed [24:0] rsp_roll_angle,
   output logic signed [24:0] rsp_yaw_angle,
   output logic [31:0]        rsp_sample_count,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [7:0]         csr_index,
   input  logic [23:0]        csr_wdata
);

   imucf_pkg::cmd_type cmd;

   assign csr_ready = 1'b1;

   // Sequencer.
   imucf_ctrl #(
      .CORDIC_ITERATIONS(CORDIC_ITERATIONS)
   ) u_ctrl (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_read_failed (req_read_failed),
      .req_ready       (req_ready),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .cmd             (cmd)
   );

   // Arithmetic and state.
   imucf_datapath u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .csr_valid        (csr_valid),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .req_accel_x      (req_accel_x),
      .req_accel_y      (req_accel_y),
      .req_accel_z      (req_accel_z),
      .req_gyro_x       (req_gyro_x),
      .req_gyro_y       (req_gyro_y),
      .req_gyro_z       (req_gyro_z),
      .rsp_pitch_angle  (rsp_pitch_angle),
      .rsp_roll_angle   (rsp_roll_angle),
      .rsp_yaw_angle    (rsp_yaw_angle),
      .rsp_sample_count (rsp_sample_count)
   );

endmodule
